### hw/rtl/aip_pkg.sv
package aip_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int OFFSET_W    = 12;
  localparam int DIGIT_W     = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((VALUE_W + OFFSET_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - OFFSET_W;

  localparam int STRING_MAX_DFLT = 4095;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic               is_blank;
    logic               is_plus;
    logic               is_minus;
    logic               is_dec;
    logic               is_x;
    logic               is_alpha;   // a-f or A-F
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    logic                number_found;
  } aip_result_t;

endpackage

### hw/rtl/aip_char_class.sv
module aip_char_class (
  input  logic [aip_pkg::CHAR_W-1:0] character,
  output aip_pkg::char_class_t       cls
);
  import aip_pkg::*;

  logic             lower;
  logic             upper;
  logic [CHAR_W-1:0] alpha_val;

  always_comb begin
    lower     = (character >= CH_LA) && (character <= CH_LF);
    upper     = (character >= CH_UA) && (character <= CH_UF);
    // letter value: low nibble of the code is 1..6 for both cases
    alpha_val = {4'b0, character[3:0]} + 8'd9;

    cls          = '0;
    cls.is_blank = ((character >= CH_TAB) && (character <= CH_CR)) || (character == CH_SPACE);
    cls.is_plus  = (character == CH_PLUS);
    cls.is_minus = (character == CH_MINUS);
    cls.is_dec   = (character >= CH_0) && (character <= CH_9);
    cls.is_x     = (character == CH_LX) || (character == CH_UX);
    cls.is_alpha = lower || upper;
    if (cls.is_dec) begin
      cls.digit = character[DIGIT_W-1:0];
    end else begin
      cls.digit = alpha_val[DIGIT_W-1:0];
    end
  end

endmodule

### hw/rtl/aip_core.sv
module aip_core #(
  parameter int STRING_MAX = aip_pkg::STRING_MAX_DFLT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  aip_pkg::char_class_t cls,
  output logic                 res_valid,
  output aip_pkg::aip_result_t res
);
  import aip_pkg::*;

  localparam int PosW = $clog2(STRING_MAX + 1);

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic                 minus_r, minus_nxt;
  logic                 hex_r, hex_nxt;
  logic [PosW-1:0]      pos_r, pos_nxt;
  logic                 seen_r, seen_nxt;

  logic                 taken;
  logic [VALUE_W-1:0]   digit_ext;
  logic [VALUE_W-1:0]   acc_x10;
  logic [VALUE_W-1:0]   acc_x16;
  logic [PosW+OFFSET_W-1:0] pos_ext;

  assign digit_ext = {{(VALUE_W-DIGIT_W){1'b0}}, cls.digit};
  assign acc_x10   = {acc_r[VALUE_W-4:0], 3'b000} + {acc_r[VALUE_W-2:0], 1'b0} + digit_ext;
  assign acc_x16   = {acc_r[VALUE_W-5:0], cls.digit};
  assign pos_ext   = {{OFFSET_W{1'b0}}, pos_r};

  always_comb begin
    taken     = 1'b0;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    minus_nxt = minus_r;
    hex_nxt   = hex_r;
    seen_nxt  = seen_r;

    case (phase_r)
      PH_SPACE, PH_SIGNED: begin
        if ((phase_r == PH_SPACE) && cls.is_blank) begin
          taken = 1'b1;
        end else if ((phase_r == PH_SPACE) && (cls.is_plus || cls.is_minus)) begin
          taken     = 1'b1;
          minus_nxt = cls.is_minus;
          phase_nxt = PH_SIGNED;
        end else if (cls.is_dec) begin
          // first digit; a leading zero may open a hex prefix
          taken     = 1'b1;
          seen_nxt  = 1'b1;
          acc_nxt   = digit_ext;
          phase_nxt = (cls.digit == '0) ? PH_ZERO : PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if (cls.is_x) begin
          taken     = 1'b1;
          hex_nxt   = 1'b1;
          phase_nxt = PH_DIGITS;
        end else if (cls.is_dec) begin
          taken     = 1'b1;
          acc_nxt   = digit_ext;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (cls.is_dec || (hex_r && cls.is_alpha)) begin
          taken   = 1'b1;
          acc_nxt = hex_r ? acc_x16 : acc_x10;
        end
      end
      default: begin
        phase_nxt = PH_SPACE;
      end
    endcase

    if (taken && (pos_r < PosW'(STRING_MAX))) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  // terminating character: report, then start over
  assign res_valid        = accept && !taken;
  assign res.number_found = seen_r;
  assign res.value        = !seen_r ? '0 : (minus_r ? ('0 - acc_r) : acc_r);
  assign res.end_offset   = seen_r ? pos_ext[OFFSET_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && !taken)) begin
      phase_r <= PH_SPACE;
      acc_r   <= '0;
      minus_r <= 1'b0;
      hex_r   <= 1'b0;
      pos_r   <= '0;
      seen_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      minus_r <= minus_nxt;
      hex_r   <= hex_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

### hw/rtl/ascii_integer_parser.sv
// Streaming string-to-integer converter. One character enters per item, one item per clock
// when the output side keeps up; the parse state (phase, 64-bit accumulator, sign, base,
// position) lives in one register bank that the character updates with a
// shift-add of the accumulator. Leading white space, a leading sign, a 0x prefix and digits
// produce nothing; the first other character (NUL always counts as one) produces one result
// item in the output register in the next cycle and clears the state, so the next string may
// follow at once. A result carries the value (negated for '-'), the offset of the terminating
// character (saturating at STRING_MAX, low 12 bits shown) and a found flag; with no digit both
// value and offset are zero. Input is stalled only while a result sits in the output register
// and is not being taken. No clearing pass after reset.
module ascii_integer_parser #(
  parameter int STRING_MAX = aip_pkg::STRING_MAX_DFLT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [aip_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] character
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [aip_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [63:0] value, [75:64] end_offset
  output logic                             out_tuser   // [0] number_found
);
  import aip_pkg::*;

  char_class_t cls;
  aip_result_t res;
  logic        res_valid;
  logic        accept;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  aip_char_class u_class (
    .character (in_tdata[CHAR_W-1:0]),
    .cls       (cls)
  );

  aip_core #(
    .STRING_MAX (STRING_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, res.end_offset, res.value};
      out_user_r <= res.number_found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### hw/rtl/aip_checker.sv
module aip_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [aip_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);
  import aip_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no number: value and offset are zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero payload without a number");

  // free output slot never stalls input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a result that raises out_tvalid follows an accepted character
  a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without input");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (.*);
